/* hdl/pedhh_pkg.sv */
`timescale 1ns / 1ps

package pedhh_pkg;

   localparam int TAG_BITS       = 16;
   localparam int EVENT_BITS     = 32;
   localparam int HIT_COUNT_BITS = 32;
   localparam int STATUS_BITS    = 3;
   localparam int REQ_BITS       = 2;
   localparam int SERVER_BITS    = 3;
   localparam int LINK_BITS      = 4;
   localparam int CHIP_BITS      = 5;
   localparam int STRIP_BITS     = 7;

   localparam logic [REQ_BITS-1:0] REQ_HIT   = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_CLOSE = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd2;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_COUNTED = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_BADKEY  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_CLOSED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_READ    = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd5;

   localparam logic [TAG_BITS-1:0]   TAG_FIRST = 16'd1;
   localparam logic [TAG_BITS-1:0]   TAG_LAST  = 16'hFFFF;
   localparam logic [EVENT_BITS-1:0] EVENT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic capture;
      logic clear;
      logic idx_a;
      logic idx_b;
      logic idx_c;
      logic mem_read;
      logic update;
      logic close;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic tag_wrap;
      logic sweep_last;
   } stat_type;

endpackage

/* hdl/pedhh_ram.sv */
`timescale 1ns / 1ps

module pedhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pedhh_ctrl.sv */
`timescale 1ns / 1ps

module pedhh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_type,
   input  pedhh_pkg::stat_type       stat,
   output pedhh_pkg::cmd_type        cmd,
   output logic                      busy
);

   import pedhh_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_IDX_A  = 8'b0000_0010,
      S_IDX_B  = 8'b0000_0100,
      S_IDX_C  = 8'b0000_1000,
      S_READ   = 8'b0001_0000,
      S_UPDATE = 8'b0010_0000,
      S_CLOSE  = 8'b0100_0000,
      S_SWEEP  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_type)
                  REQ_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  REQ_CLOSE: state_in = S_CLOSE;
                  REQ_HIT, REQ_READ: state_in = S_IDX_A;
                  default: state_in = S_IDX_A;
               endcase
            end
         end
         S_IDX_A: begin
            cmd.idx_a = 1'b1;
            state_in  = S_IDX_B;
         end
         S_IDX_B: begin
            cmd.idx_b = 1'b1;
            state_in  = S_IDX_C;
         end
         S_IDX_C: begin
            cmd.idx_c = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = stat.tag_wrap ? S_SWEEP : S_IDLE;
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory clearing pass runs straight out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* hdl/pedhh_dp.sv */
`timescale 1ns / 1ps

module pedhh_dp #(
   parameter int NUM_SERVERS = 8,
   parameter int NUM_LINKS   = 14,
   parameter int NUM_CHIPS   = 26,
   parameter int NUM_STRIPS  = 128,
   parameter int COUNT_BITS  = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pedhh_pkg::cmd_type                        cmd,
   output pedhh_pkg::stat_type                       stat,
   input  logic [pedhh_pkg::REQ_BITS-1:0]            req_type,
   input  logic [pedhh_pkg::SERVER_BITS-1:0]         req_server_id,
   input  logic [pedhh_pkg::LINK_BITS-1:0]           req_link_id,
   input  logic [pedhh_pkg::CHIP_BITS-1:0]           req_chip_id,
   input  logic [pedhh_pkg::STRIP_BITS-1:0]          req_strip_id,
   output logic                                      rsp_valid,
   output logic [pedhh_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [pedhh_pkg::HIT_COUNT_BITS-1:0]      rsp_hit_count,
   output logic [pedhh_pkg::EVENT_BITS-1:0]          rsp_event_count
);

   import pedhh_pkg::*;

   localparam int TOTAL     = NUM_SERVERS * NUM_LINKS * NUM_CHIPS * NUM_STRIPS;
   localparam int ADDR_BITS = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [ADDR_BITS-1:0]  LAST_ADDR  = ADDR_BITS'(TOTAL - 1);

   // captured item
   logic [REQ_BITS-1:0]    type_ff;
   logic [SERVER_BITS-1:0] server_ff;
   logic [LINK_BITS-1:0]   link_ff;
   logic [CHIP_BITS-1:0]   chip_ff;
   logic [STRIP_BITS-1:0]  strip_ff;
   logic [ADDR_BITS-1:0]   idx_ff;

   logic [EVENT_BITS-1:0] event_count_ff, event_count_in;
   logic                  had_hit_ff, had_hit_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [ADDR_BITS-1:0]  sweep_addr_ff, sweep_addr_in;
   logic                  sweep_counts_ff, sweep_counts_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [HIT_COUNT_BITS-1:0] rsp_hit_count_ff, rsp_hit_count_in;
   logic [EVENT_BITS-1:0]     rsp_event_count_ff, rsp_event_count_in;

   logic                  key_ok;
   logic                  is_hit;
   logic                  is_read;
   logic                  hit_new;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic [COUNT_BITS-1:0] cnt_next;
   logic [TAG_BITS-1:0]   tag_rd;
   logic                  cnt_we;
   logic                  tag_we;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic [TAG_BITS-1:0]   tag_wr_data;

   assign key_ok = (int'(server_ff) < NUM_SERVERS) && (int'(link_ff) < NUM_LINKS) &&
                   (int'(chip_ff) < NUM_CHIPS) && (int'(strip_ff) < NUM_STRIPS);
   assign is_hit  = (type_ff == REQ_HIT);
   assign is_read = (type_ff == REQ_READ);

   // channel index built one multiply per cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_type;
         server_ff <= req_server_id;
         link_ff   <= req_link_id;
         chip_ff   <= req_chip_id;
         strip_ff  <= req_strip_id;
      end
      if (cmd.idx_a) begin
         idx_ff <= ADDR_BITS'(server_ff) * ADDR_BITS'(NUM_LINKS) + ADDR_BITS'(link_ff);
      end
      if (cmd.idx_b) begin
         idx_ff <= idx_ff * ADDR_BITS'(NUM_CHIPS) + ADDR_BITS'(chip_ff);
      end
      if (cmd.idx_c) begin
         idx_ff <= idx_ff * ADDR_BITS'(NUM_STRIPS) + ADDR_BITS'(strip_ff);
      end
   end

   assign cnt_next = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
   assign hit_new  = is_hit && key_ok && (tag_rd != tag_ff);

   assign cnt_we      = (cmd.sweep && sweep_counts_ff) || (cmd.update && hit_new);
   assign tag_we      = cmd.sweep || (cmd.update && hit_new);
   assign wr_addr     = cmd.sweep ? sweep_addr_ff : idx_ff;
   assign rd_addr     = key_ok ? idx_ff : '0;
   assign cnt_wr_data = cmd.sweep ? '0 : cnt_next;
   assign tag_wr_data = cmd.sweep ? '0 : tag_ff;

   pedhh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TOTAL)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   pedhh_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (TOTAL)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   always_comb begin
      event_count_in     = event_count_ff;
      had_hit_in         = had_hit_ff;
      tag_in             = tag_ff;
      sweep_addr_in      = sweep_addr_ff;
      sweep_counts_in    = sweep_counts_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = ST_BADKEY;
      rsp_hit_count_in   = '0;
      rsp_event_count_in = event_count_ff;

      if (cmd.sweep) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end

      if (cmd.clear) begin
         event_count_in     = '0;
         had_hit_in         = 1'b0;
         tag_in             = TAG_FIRST;
         sweep_addr_in      = '0;
         sweep_counts_in    = 1'b1;
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ST_CLEARED;
         rsp_event_count_in = '0;
      end

      if (cmd.close) begin
         if (had_hit_ff && (event_count_ff != EVENT_MAX)) begin
            event_count_in = event_count_ff + 1'b1;
         end
         had_hit_in = 1'b0;
         if (tag_ff == TAG_LAST) begin
            tag_in          = TAG_FIRST;
            sweep_addr_in   = '0;
            sweep_counts_in = 1'b0;
         end else begin
            tag_in = tag_ff + 1'b1;
         end
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ST_CLOSED;
         rsp_event_count_in = event_count_in;
      end

      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         if (is_hit) begin
            had_hit_in = 1'b1;
         end
         priority if (!key_ok) begin
            rsp_status_in = ST_BADKEY;
         end else if (is_hit) begin
            rsp_status_in = hit_new ? ST_COUNTED : ST_DUP;
         end else if (is_read) begin
            rsp_status_in    = ST_READ;
            rsp_hit_count_in = HIT_COUNT_BITS'(cnt_rd);
         end else begin
            rsp_status_in = ST_BADKEY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff  <= '0;
         had_hit_ff      <= 1'b0;
         tag_ff          <= TAG_FIRST;
         sweep_addr_ff   <= '0;
         sweep_counts_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         event_count_ff  <= event_count_in;
         had_hit_ff      <= had_hit_in;
         tag_ff          <= tag_in;
         sweep_addr_ff   <= sweep_addr_in;
         sweep_counts_ff <= sweep_counts_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_hit_count_ff   <= rsp_hit_count_in;
      rsp_event_count_ff <= rsp_event_count_in;
   end

   assign stat.tag_wrap   = (tag_ff == TAG_LAST);
   assign stat.sweep_last = (sweep_addr_ff == LAST_ADDR);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit_count   = rsp_hit_count_ff;
   assign rsp_event_count = rsp_event_count_ff;

endmodule

/* hdl/per_event_dedup_hit_histogram.sv */
`timescale 1ns / 1ps

// Channel occupancy histogram with per-event de-duplication. An item is taken when start is
// high and busy is low; every item gives exactly one result, shown for one cycle with
// rsp_valid high, and the receiver cannot hold it off. For a hit or read, the states
// S_IDX_A, S_IDX_B and S_IDX_C build the channel index one constant multiply at a time,
// S_READ reads the counter and tag memories (registered read), S_UPDATE updates them, and
// the next item can be taken in the cycle its result is shown. An end of event gives its
// result from the S_CLOSE state. After reset, after a clear item, and after the end of
// every 65535th event the block is busy while it clears the memories one entry a cycle
// (after an end of event, the tag memory only); the result of the clear item, or of the
// end of event that starts the pass, is shown in the first cycle of that pass.

module per_event_dedup_hit_histogram #(
   parameter int NUM_SERVERS = 8,
   parameter int NUM_LINKS   = 14,
   parameter int NUM_CHIPS   = 26,
   parameter int NUM_STRIPS  = 128,
   parameter int COUNT_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pedhh_pkg::REQ_BITS-1:0]       req_type,
   input  logic [pedhh_pkg::SERVER_BITS-1:0]    req_server_id,
   input  logic [pedhh_pkg::LINK_BITS-1:0]      req_link_id,
   input  logic [pedhh_pkg::CHIP_BITS-1:0]      req_chip_id,
   input  logic [pedhh_pkg::STRIP_BITS-1:0]     req_strip_id,
   output logic                                 rsp_valid,
   output logic [pedhh_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [pedhh_pkg::HIT_COUNT_BITS-1:0] rsp_hit_count,
   output logic [pedhh_pkg::EVENT_BITS-1:0]     rsp_event_count
);

   import pedhh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pedhh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   pedhh_dp #(
      .NUM_SERVERS (NUM_SERVERS),
      .NUM_LINKS   (NUM_LINKS),
      .NUM_CHIPS   (NUM_CHIPS),
      .NUM_STRIPS  (NUM_STRIPS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_server_id   (req_server_id),
      .req_link_id     (req_link_id),
      .req_chip_id     (req_chip_id),
      .req_strip_id    (req_strip_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_event_count (rsp_event_count)
   );

endmodule

/* bench/per_event_dedup_hit_histogram_test.sv */
`timescale 1ns / 1ps

module per_event_dedup_hit_histogram_test;
   import pedhh_pkg::*;

   localparam int NUM_SERVERS  = 8;
   localparam int NUM_LINKS    = 14;
   localparam int NUM_CHIPS    = 26;
   localparam int NUM_STRIPS   = 128;
   localparam int COUNT_BITS   = 32;
   localparam int CHANNELS     = NUM_SERVERS * NUM_LINKS * NUM_CHIPS * NUM_STRIPS;
   localparam int STALL_LIMIT  = 4 * CHANNELS;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CALM_TAIL    = 150;
   localparam int POOL_SIZE    = 16;
   localparam logic [HIT_COUNT_BITS-1:0] COUNT_MAX =
      HIT_COUNT_BITS'((64'd1 << COUNT_BITS) - 64'd1);

   typedef struct packed {
      logic [SERVER_BITS-1:0] server;
      logic [LINK_BITS-1:0]   link;
      logic [CHIP_BITS-1:0]   chip;
      logic [STRIP_BITS-1:0]  strip;
   } chan_key_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [HIT_COUNT_BITS-1:0] hit_count;
      logic [EVENT_BITS-1:0]     event_count;
   } occ_result_type;

   typedef enum {KEY_GOOD, KEY_ANY, KEY_BAD} key_mode_type;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      start         = 1'b0;
   logic                      busy;
   logic [REQ_BITS-1:0]       req_type      = REQ_HIT;
   logic [SERVER_BITS-1:0]    req_server_id = '0;
   logic [LINK_BITS-1:0]      req_link_id   = '0;
   logic [CHIP_BITS-1:0]      req_chip_id   = '0;
   logic [STRIP_BITS-1:0]     req_strip_id  = '0;
   logic                      rsp_valid;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [HIT_COUNT_BITS-1:0] rsp_hit_count;
   logic [EVENT_BITS-1:0]     rsp_event_count;

   per_event_dedup_hit_histogram #(
      .NUM_SERVERS (NUM_SERVERS),
      .NUM_LINKS   (NUM_LINKS),
      .NUM_CHIPS   (NUM_CHIPS),
      .NUM_STRIPS  (NUM_STRIPS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_server_id   (req_server_id),
      .req_link_id     (req_link_id),
      .req_chip_id     (req_chip_id),
      .req_strip_id    (req_strip_id),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_event_count (rsp_event_count)
   );

   // occupancy state as the block should hold it
   bit [HIT_COUNT_BITS-1:0] channel_tally [CHANNELS];
   bit [TAG_BITS-1:0]       channel_tag   [CHANNELS];
   bit [TAG_BITS-1:0]       current_tag   = TAG_FIRST;
   bit [EVENT_BITS-1:0]     hit_events    = '0;
   bit                      event_touched = 1'b0;

   occ_result_type pending_results[$];
   int             mismatches      = 0;
   int             items_sent      = 0;
   int             results_checked = 0;
   int             dup_seen        = 0;
   int             bad_seen        = 0;
   int             stall_cycles    = 0;
   bit             idling          = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic chan_key_type key_of(input int s, input int l, input int c, input int st);
      chan_key_type k;
      k.server = s[SERVER_BITS-1:0];
      k.link   = l[LINK_BITS-1:0];
      k.chip   = c[CHIP_BITS-1:0];
      k.strip  = st[STRIP_BITS-1:0];
      return k;
   endfunction

   function automatic chan_key_type random_key(input key_mode_type mode);
      chan_key_type k;
      k = key_of($urandom_range(0, NUM_SERVERS - 1), $urandom_range(0, NUM_LINKS - 1),
                 $urandom_range(0, NUM_CHIPS - 1), $urandom_range(0, NUM_STRIPS - 1));
      case (mode)
         KEY_ANY: begin
            k = chan_key_type'($urandom);
         end
         KEY_BAD: begin
            if ($urandom_range(0, 1))
               k.link = LINK_BITS'($urandom_range(NUM_LINKS, (1 << LINK_BITS) - 1));
            else
               k.chip = CHIP_BITS'($urandom_range(NUM_CHIPS, (1 << CHIP_BITS) - 1));
         end
         default: ;
      endcase
      return k;
   endfunction

   function automatic occ_result_type predict_occupancy(input logic [REQ_BITS-1:0] kind,
                                                        input chan_key_type key);
      occ_result_type r;
      int unsigned idx;
      bit          good;
      r.status    = ST_BADKEY;
      r.hit_count = '0;
      good = key.server < NUM_SERVERS && key.link < NUM_LINKS &&
             key.chip < NUM_CHIPS && key.strip < NUM_STRIPS;
      idx = ((key.server * NUM_LINKS + key.link) * NUM_CHIPS + key.chip) * NUM_STRIPS
            + key.strip;
      case (kind)
         REQ_HIT: begin
            event_touched = 1'b1;
            if (good) begin
               if (channel_tag[idx] == current_tag) begin
                  r.status = ST_DUP;
               end else begin
                  channel_tag[idx] = current_tag;
                  if (channel_tally[idx] != COUNT_MAX)
                     channel_tally[idx] = channel_tally[idx] + 1'b1;
                  r.status = ST_COUNTED;
               end
            end
         end
         REQ_CLOSE: begin
            if (event_touched && hit_events != EVENT_MAX)
               hit_events = hit_events + 1'b1;
            event_touched = 1'b0;
            if (current_tag == TAG_LAST) begin
               foreach (channel_tag[i]) channel_tag[i] = '0;
               current_tag = TAG_FIRST;
            end else begin
               current_tag = current_tag + 1'b1;
            end
            r.status = ST_CLOSED;
         end
         REQ_READ: begin
            if (good) begin
               r.hit_count = channel_tally[idx];
               r.status    = ST_READ;
            end
         end
         default: begin
            foreach (channel_tally[i]) channel_tally[i] = '0;
            foreach (channel_tag[i]) channel_tag[i] = '0;
            current_tag   = TAG_FIRST;
            hit_events    = '0;
            event_touched = 1'b0;
            r.status      = ST_CLEARED;
         end
      endcase
      r.event_count = hit_events;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // one item: hold it until taken, then maybe let the line idle for a burst
   task automatic send_item(input logic [REQ_BITS-1:0] kind, input chan_key_type key);
      start         <= 1'b1;
      req_type      <= kind;
      req_server_id <= key.server;
      req_link_id   <= key.link;
      req_chip_id   <= key.chip;
      req_strip_id  <= key.strip;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_results.push_back(predict_occupancy(kind, key));
      items_sent++;
      if (idling && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : check_results
      occ_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                      rsp_status));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.status == ST_DUP) dup_seen++;
            if (want.status == ST_BADKEY) bad_seen++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         results_checked, rsp_status, want.status));
            if (rsp_hit_count !== want.hit_count)
               report_mismatch($sformatf("result %0d hit_count %0d, want %0d",
                                         results_checked, rsp_hit_count, want.hit_count));
            if (rsp_event_count !== want.event_count)
               report_mismatch($sformatf("result %0d event_count %0d, want %0d",
                                         results_checked, rsp_event_count, want.event_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", stall_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_key_extremes();
      chan_key_type lo, hi, ones;
      lo   = key_of(0, 0, 0, 0);
      hi   = key_of(NUM_SERVERS - 1, NUM_LINKS - 1, NUM_CHIPS - 1, NUM_STRIPS - 1);
      ones = key_of(-1, -1, -1, -1);
      send_item(REQ_HIT, lo);
      send_item(REQ_HIT, hi);
      send_item(REQ_HIT, hi);
      send_item(REQ_HIT, key_of(0, NUM_LINKS, 0, 0));
      send_item(REQ_HIT, key_of(0, 0, NUM_CHIPS, 0));
      send_item(REQ_HIT, ones);
      send_item(REQ_READ, lo);
      send_item(REQ_READ, hi);
      send_item(REQ_READ, ones);
      send_item(REQ_CLOSE, ones);
      // empty event, then one holding only an out-of-range hit
      send_item(REQ_CLOSE, lo);
      send_item(REQ_HIT, key_of(NUM_SERVERS - 1, NUM_LINKS + 1, 0, 0));
      send_item(REQ_CLOSE, hi);
      send_item(REQ_HIT, lo);
      send_item(REQ_HIT, lo);
      send_item(REQ_READ, lo);
      send_item(REQ_CLOSE, lo);
   endtask

   task automatic test_clear();
      chan_key_type k;
      k = random_key(KEY_GOOD);
      send_item(REQ_HIT, k);
      send_item(REQ_CLOSE, k);
      send_item(REQ_HIT, k);
      send_item(REQ_CLEAR, key_of(-1, -1, -1, -1));
      send_item(REQ_CLOSE, k);
      send_item(REQ_READ, k);
      send_item(REQ_HIT, k);
      send_item(REQ_CLOSE, k);
   endtask

   // mostly whole events over a small channel pool so repeats and counts build up
   task automatic test_random_traffic();
      chan_key_type pool [POOL_SIZE];
      int           stop_at;
      int           roll;
      foreach (pool[i]) pool[i] = random_key(KEY_GOOD);
      pool[0] = key_of(0, 0, 0, 0);
      pool[1] = key_of(NUM_SERVERS - 1, NUM_LINKS - 1, NUM_CHIPS - 1, NUM_STRIPS - 1);
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         idling = (stop_at - items_sent > CALM_TAIL) && ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0: begin
               send_item(REQ_CLOSE, random_key(KEY_ANY));
            end
            1: begin
               repeat ($urandom_range(1, 4))
                  send_item(REQ_BITS'($urandom_range(0, 2)), random_key(KEY_ANY));
            end
            default: begin
               repeat ($urandom_range(1, 12)) begin
                  roll = $urandom_range(0, 9);
                  send_item(roll == 0 ? REQ_READ : REQ_HIT,
                            roll < 7 ? pool[$urandom_range(0, POOL_SIZE - 1)] :
                            random_key(roll == 9 ? KEY_BAD : KEY_ANY));
               end
               repeat ($urandom_range(0, 3))
                  send_item(REQ_READ, pool[$urandom_range(0, POOL_SIZE - 1)]);
               send_item(REQ_CLOSE, random_key(KEY_ANY));
            end
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_key_extremes();
      test_clear();
      test_random_traffic();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("covered %0d items and %0d results, %0d repeats and %0d out-of-range keys",
               items_sent, results_checked, dup_seen, bad_seen);
      $display("key extremes and full clear exercised, %0d events with hits at the end",
               hit_events);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* per_event_dedup_hit_histogram.f */
hdl/pedhh_pkg.sv
hdl/pedhh_ram.sv
hdl/pedhh_ctrl.sv
hdl/pedhh_dp.sv
hdl/per_event_dedup_hit_histogram.sv
bench/per_event_dedup_hit_histogram_test.sv
